@@ src/brqc_pkg.sv @@
// Shared types and constants for the button qualifier and recoil controller.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package brqc_pkg;

  // fixed field widths of the request and result channels
  localparam int BTN_FIELD_W = 9;
  localparam int MODE_W      = 3;
  localparam int RECOIL_W    = 2;
  localparam int LOCK_W      = 8;

  // lockout register reset value
  localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 8'd3;

  // parameter defaults
  localparam int NUM_BUTTONS_DEF   = 9;
  localparam int AUTO_COOLDOWN_DEF = 6;

  // fixed button positions
  localparam int TRG_IDX = 0;
  localparam int RLD_IDX = 1;
  localparam int MAG_IDX = 2;
  localparam int BT0_IDX = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_SERVICE  = 3'd1,
    MODE_CAL_TL   = 3'd2,
    MODE_CAL_LR   = 3'd3,
    MODE_SHUTDOWN = 3'd4
  } mode_t;

  typedef enum logic [RECOIL_W-1:0] {
    RCL_SELF = 2'd0,
    RCL_AUTO = 2'd1,
    RCL_OFF  = 2'd2
  } recoil_t;

  // what the merge stage decides for one request
  typedef struct packed {
    logic    solenoid;
    mode_t   mode;
    recoil_t recoil;
    logic    lamp;
    logic    cap_tl;
    logic    cap_lr;
    logic    shut;
  } mode_res_t;

endpackage

@@ src/brqc_if.sv @@
// Channel interfaces: request, result and lockout configuration write.
// Depends on brqc_pkg for the field widths.
`timescale 1ns / 1ps

interface brqc_in_if import brqc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BTN_FIELD_W-1:0] edge_flags;
  logic [BTN_FIELD_W-1:0] pin_levels;

  modport source (output valid, edge_flags, pin_levels, input ready);
  modport sink   (input valid, edge_flags, pin_levels, output ready);
endinterface

interface brqc_out_if import brqc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BTN_FIELD_W-1:0] pressed_mask;
  logic [BTN_FIELD_W-1:0] new_press_mask;
  logic                   solenoid_fire;
  logic [MODE_W-1:0]      operating_mode;
  logic [RECOIL_W-1:0]    recoil_setting;
  logic                   calibration_led;
  logic                   capture_top_left;
  logic                   capture_low_right;
  logic                   shutdown_request;

  modport source (output valid, pressed_mask, new_press_mask, solenoid_fire, operating_mode,
                  recoil_setting, calibration_led, capture_top_left, capture_low_right,
                  shutdown_request, input ready);
  modport sink   (input valid, pressed_mask, new_press_mask, solenoid_fire, operating_mode,
                  recoil_setting, calibration_led, capture_top_left, capture_low_right,
                  shutdown_request, output ready);
endinterface

interface brqc_cfg_if import brqc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LOCK_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ src/brqc_lane.sv @@
// One button lane: ready / pressed / recharge phase with lockout countdown.
// Depends on brqc_pkg for the lockout width.
`timescale 1ns / 1ps

module brqc_lane import brqc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              edge_flag,
  input  logic              pin_level,
  input  logic [LOCK_W-1:0] lockout,
  output logic              fresh,
  output logic              held_nxt
);

  logic              pressed_r, pressed_nxt;
  logic [LOCK_W-1:0] count_r, count_nxt;
  logic              ready_ph;

  // phase update for this request
  always_comb begin
    ready_ph    = !pressed_r && (count_r == '0);
    fresh       = 1'b0;
    pressed_nxt = pressed_r;
    count_nxt   = count_r;
    priority if (edge_flag && ready_ph) begin
      fresh       = 1'b1;
      pressed_nxt = 1'b1;
    end else if (pin_level && pressed_r) begin
      pressed_nxt = 1'b0;
      count_nxt   = lockout;
    end else if (count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign held_nxt = pressed_nxt;

  // phase registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      count_r   <= '0;
    end else if (step) begin
      pressed_r <= pressed_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

@@ src/brqc_mode.sv @@
// Merge stage: recoil pulse timing and operating mode machine over all lanes.
// Depends on brqc_pkg for mode and recoil codes and the result struct.
`timescale 1ns / 1ps

module brqc_mode import brqc_pkg::*; #(
  parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
  parameter int AUTO_COOLDOWN = AUTO_COOLDOWN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [NUM_BUTTONS-1:0] fresh,
  input  logic [NUM_BUTTONS-1:0] held,
  output mode_res_t              res
);

  localparam int CD_W    = $clog2(AUTO_COOLDOWN + 1);
  localparam int CAL_IDX = NUM_BUTTONS - 1;
  localparam int BT_SEL  = (NUM_BUTTONS > BT0_IDX) ? BT0_IDX : 0;
  localparam logic [NUM_BUTTONS-1:0] SHUT3_MASK =
    NUM_BUTTONS'((1 << TRG_IDX) | (1 << RLD_IDX) | (1 << MAG_IDX));
  localparam logic [NUM_BUTTONS-1:0] SHUT2_MASK =
    NUM_BUTTONS'((1 << TRG_IDX) | (1 << MAG_IDX));

  mode_t            mode_r, mode_nxt;
  recoil_t          recoil_r, recoil_nxt;
  logic [CD_W-1:0]  cooldown_r, cooldown_nxt;
  logic             lamp_r, lamp_nxt;
  logic             fire, cap_tl, cap_lr, shut;
  logic             trg_new, cal_new, bt0_new;

  assign trg_new = fresh[TRG_IDX];
  assign cal_new = fresh[CAL_IDX];
  assign bt0_new = (NUM_BUTTONS > BT0_IDX) && fresh[BT_SEL];

  // mode and recoil rules
  always_comb begin
    mode_nxt     = mode_r;
    recoil_nxt   = recoil_r;
    lamp_nxt     = lamp_r;
    fire         = 1'b0;
    cap_tl       = 1'b0;
    cap_lr       = 1'b0;
    shut         = 1'b0;
    cooldown_nxt = (cooldown_r != '0) ? cooldown_r - 1'b1 : cooldown_r;

    unique case (mode_r)
      MODE_IDLE: begin
        if (recoil_r == RCL_AUTO) begin
          if (held[TRG_IDX] && cooldown_nxt == '0) begin
            fire         = 1'b1;
            cooldown_nxt = CD_W'(AUTO_COOLDOWN);
          end
        end else if (recoil_r == RCL_SELF) begin
          if (trg_new) fire = 1'b1;
        end
        if (cal_new) begin
          lamp_nxt = 1'b1;
          mode_nxt = MODE_SERVICE;
        end
      end
      MODE_SERVICE: begin
        if (trg_new) mode_nxt = MODE_CAL_TL;
        if (cal_new) begin
          mode_nxt = MODE_IDLE;
          lamp_nxt = 1'b0;
        end
        if (bt0_new) begin
          unique case (recoil_r)
            RCL_SELF: recoil_nxt = RCL_AUTO;
            RCL_AUTO: recoil_nxt = RCL_OFF;
            default: begin
              recoil_nxt = RCL_SELF;
              fire       = 1'b1;
            end
          endcase
        end
        if (held == SHUT3_MASK) begin
          mode_nxt = MODE_SHUTDOWN;
          shut     = 1'b1;
        end
      end
      MODE_CAL_TL: begin
        if (trg_new) begin
          cap_tl   = 1'b1;
          mode_nxt = MODE_CAL_LR;
        end else if (cal_new) begin
          mode_nxt = MODE_IDLE;
          lamp_nxt = 1'b0;
        end
      end
      MODE_CAL_LR: begin
        if (trg_new || cal_new) begin
          cap_lr   = trg_new;
          mode_nxt = MODE_IDLE;
          lamp_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // late shutdown combination
    if (held == SHUT2_MASK && mode_nxt == MODE_SERVICE) begin
      mode_nxt = MODE_SHUTDOWN;
      shut     = 1'b1;
    end
  end

  // the solenoid pulse lasts exactly the request that fires it
  assign res.solenoid = fire;
  assign res.mode     = mode_nxt;
  assign res.recoil   = recoil_nxt;
  assign res.lamp     = lamp_nxt;
  assign res.cap_tl   = cap_tl;
  assign res.cap_lr   = cap_lr;
  assign res.shut     = shut;

  // mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      recoil_r   <= RCL_SELF;
      cooldown_r <= '0;
      lamp_r     <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      recoil_r   <= recoil_nxt;
      cooldown_r <= cooldown_nxt;
      lamp_r     <= lamp_nxt;
    end
  end

`ifndef ASSERT_OFF
  // shutdown is left only through reset
  a_shutdown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_SHUTDOWN |=> mode_r == MODE_SHUTDOWN)
    else $error("shutdown mode was left");

  // auto cooldown never exceeds its reload value
  a_cooldown_range: assert property (@(posedge clk) disable iff (!rst_n)
    cooldown_r <= CD_W'(AUTO_COOLDOWN))
    else $error("cooldown counter out of range");

  // the lamp is off whenever the mode is idle after a request
  a_lamp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_nxt == MODE_IDLE |-> !lamp_nxt)
    else $error("lamp on in idle");
`endif

endmodule

@@ src/button_qualifier_recoil_controller.sv @@
// Top level: lockout register, button lanes, mode merge stage, output register.
// Depends on brqc_pkg, brqc_if, brqc_lane and brqc_mode.
// Each accepted request has its result in the output register in the next cycle.
// Throughput: one request per cycle while results are taken; the output register lets a new
// request in while the held result is taken in the same cycle.
// Reset: synchronous active-low rst_n clears all lanes to ready, mode to idle,
// recoil to self, the lamp off and the lockout register to 3.
`timescale 1ns / 1ps

module button_qualifier_recoil_controller import brqc_pkg::*; #(
  parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
  parameter int AUTO_COOLDOWN = AUTO_COOLDOWN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  brqc_in_if.sink     in_ch,
  brqc_out_if.source  out_ch,
  brqc_cfg_if.sink    cfg_ch
);

  logic [LOCK_W-1:0]      lockout_r;
  logic                   step;
  logic [NUM_BUTTONS-1:0] fresh_vec, held_vec;
  logic [BTN_FIELD_W-1:0] fresh_field, held_field;
  mode_res_t              res;

  logic                   out_valid_r;
  logic [BTN_FIELD_W-1:0] pressed_r, new_press_r;
  mode_res_t              res_r;

  // lockout configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= LOCKOUT_RESET;
    end else if (cfg_ch.valid) begin
      lockout_r <= cfg_ch.data;
    end
  end

  // request handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  // one lane per button; lanes past the field width see no edge and a low pin
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic edge_in, pin_in;
    if (i < BTN_FIELD_W) begin : g_wired
      assign edge_in = in_ch.edge_flags[i];
      assign pin_in  = in_ch.pin_levels[i];
    end else begin : g_quiet
      assign edge_in = 1'b0;
      assign pin_in  = 1'b0;
    end
    brqc_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .edge_flag(edge_in),
      .pin_level(pin_in),
      .lockout  (lockout_r),
      .fresh    (fresh_vec[i]),
      .held_nxt (held_vec[i])
    );
  end

  // merge stage
  brqc_mode #(
    .NUM_BUTTONS  (NUM_BUTTONS),
    .AUTO_COOLDOWN(AUTO_COOLDOWN)
  ) u_mode (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .fresh(fresh_vec),
    .held (held_vec),
    .res  (res)
  );

  // fit lane vectors to the fixed mask width
  for (genvar j = 0; j < BTN_FIELD_W; j++) begin : g_mask
    if (j < NUM_BUTTONS) begin : g_have
      assign fresh_field[j] = fresh_vec[j];
      assign held_field[j]  = held_vec[j];
    end else begin : g_none
      assign fresh_field[j] = 1'b0;
      assign held_field[j]  = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pressed_r   <= held_field;
      new_press_r <= fresh_field;
      res_r       <= res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.pressed_mask      = pressed_r;
  assign out_ch.new_press_mask    = new_press_r;
  assign out_ch.solenoid_fire     = res_r.solenoid;
  assign out_ch.operating_mode    = res_r.mode;
  assign out_ch.recoil_setting    = res_r.recoil;
  assign out_ch.calibration_led   = res_r.lamp;
  assign out_ch.capture_top_left  = res_r.cap_tl;
  assign out_ch.capture_low_right = res_r.cap_lr;
  assign out_ch.shutdown_request  = res_r.shut;

`ifndef ASSERT_OFF
  // a new press is always among the held buttons
  a_fresh_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (new_press_r & ~pressed_r) == '0)
    else $error("new press not held");

  // a shutdown strobe comes with shutdown mode
  a_shut_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.shut |-> res_r.mode == MODE_SHUTDOWN)
    else $error("shutdown strobe outside shutdown");

  // corner captures advance the calibration sequence
  a_capture_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!res_r.cap_tl || res_r.mode == MODE_CAL_LR) &&
                    (!res_r.cap_lr || res_r.mode == MODE_IDLE))
    else $error("capture strobe with wrong mode");
`endif

endmodule

@@ test/tb_top.sv @@
// Testbench for the button qualifier and recoil controller: directed table, random requests, then shutdown.
// Checks every result against an in-bench tick predictor, or against the table's result for typed rows.
// Depends on brqc_pkg, brqc_if and the controller top level.
`timescale 1ns / 1ps

module tb_top import brqc_pkg::*; ();

  localparam int NB       = NUM_BUTTONS_DEF;
  localparam int CAL_IDX  = NB - 1;
  localparam int AUTO_CD  = AUTO_COOLDOWN_DEF;
  localparam int LIMIT_NS = 400_000;

  localparam logic [NB-1:0] TRG_M         = NB'(1 << TRG_IDX);
  localparam logic [NB-1:0] RLD_M         = NB'(1 << RLD_IDX);
  localparam logic [NB-1:0] MAG_M         = NB'(1 << MAG_IDX);
  localparam logic [NB-1:0] CAL_M         = NB'(1 << CAL_IDX);
  localparam logic [NB-1:0] COMBO_FULL    = TRG_M | RLD_M | MAG_M;
  localparam logic [NB-1:0] COMBO_TRG_MAG = TRG_M | MAG_M;

  // controller state as the predictor tracks it
  typedef struct packed {
    logic [NB-1:0][8:0] phase;   // 0 ready, 1 pressed, negative: recharge ticks left
    logic [NB-1:0]      held;
    mode_t              mode;
    recoil_t            recoil;
    logic [2:0]         cool;
    logic               pend;
    logic               sol;
    logic               lamp;
    logic [LOCK_W-1:0]  lockout;
  } ctl_state_t;

  // one result as seen on the result channel
  typedef struct packed {
    logic [NB-1:0] pressed;
    logic [NB-1:0] fresh;
    logic          fire;
    mode_t         mode;
    recoil_t       recoil;
    logic          lamp;
    logic          cap_tl;
    logic          cap_lr;
    logic          shut;
  } tick_res_t;

  typedef enum logic {ROW_TICK, ROW_LOCK} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [NB-1:0]     edges;
    logic [NB-1:0]     levels;
    logic [LOCK_W-1:0] lock;
    logic              typed;
    tick_res_t         want;
  } dir_row_t;

  localparam tick_res_t NO_RES = '0;
  localparam tick_res_t RES_RESET = '{pressed: '0, fresh: '0, fire: 1'b0, mode: MODE_IDLE,
    recoil: RCL_SELF, lamp: 1'b0, cap_tl: 1'b0, cap_lr: 1'b0, shut: 1'b0};
  localparam tick_res_t RES_ALL_PRESS = '{pressed: '1, fresh: '1, fire: 1'b1,
    mode: MODE_SERVICE, recoil: RCL_SELF, lamp: 1'b1, cap_tl: 1'b0, cap_lr: 1'b0,
    shut: 1'b0};
  localparam tick_res_t RES_ALL_RELEASE = '{pressed: '0, fresh: '0, fire: 1'b0,
    mode: MODE_SERVICE, recoil: RCL_SELF, lamp: 1'b1, cap_tl: 1'b0, cap_lr: 1'b0,
    shut: 1'b0};

  localparam int N_DIR = 28;
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b1, RES_RESET},
    '{ROW_TICK, 9'h1FF, 9'h1FF, 8'd0, 1'b1, RES_ALL_PRESS},
    '{ROW_TICK, 9'h1FF, 9'h1FF, 8'd0, 1'b1, RES_ALL_RELEASE},
    // edges ignored while recharging, countdown runs whatever the level
    '{ROW_TICK, 9'h1FF, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h1FF, 9'h1FF, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h1FF, 9'h0AA, 8'd0, 1'b0, NO_RES},
    // trigger and calibration together in service, bt0 steps recoil to auto
    '{ROW_TICK, 9'h1FF, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_LOCK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    // zero lockout, then auto fire with a held trigger
    '{ROW_TICK, 9'h000, 9'h1FF, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h001, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h000, 8'd0, 1'b0, NO_RES},
    // into service, recoil auto -> off -> self with a pulse
    '{ROW_TICK, 9'h000, 9'h001, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h100, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h108, 9'h108, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h008, 9'h008, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h008, 9'h000, 8'd0, 1'b0, NO_RES},
    // calibration walk: both corner captures
    '{ROW_TICK, 9'h001, 9'h008, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h001, 9'h001, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h001, 9'h000, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h000, 9'h001, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h001, 9'h000, 8'd0, 1'b0, NO_RES},
    // self mode pulse in idle
    '{ROW_TICK, 9'h000, 9'h001, 8'd0, 1'b0, NO_RES},
    '{ROW_TICK, 9'h001, 9'h000, 8'd0, 1'b0, NO_RES}
  };

  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS [N_PHASES] = '{80, 30, 70, 80, 70, 70};

  logic clk = 1'b0;
  logic rst_n;

  brqc_in_if  in_ch ();
  brqc_out_if out_ch ();
  brqc_cfg_if cfg_ch ();

  button_qualifier_recoil_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ctl_state_t ctl_state;
  tick_res_t  pending_results [$];
  tick_res_t  oldest_res;
  int         mism_count = 0;
  int         burst_left = 0;

  always #1 clk = ~clk;

  // one frame tick of the controller
  function automatic tick_res_t run_tick(inout ctl_state_t s, input logic [NB-1:0] e,
                                         input logic [NB-1:0] l);
    tick_res_t     r;
    logic [NB-1:0] fresh;
    int            ph;
    r = '0;
    fresh = '0;
    // per-button qualification
    for (int i = 0; i < NB; i++) begin
      ph = int'($signed(s.phase[i]));
      if (e[i] && ph == 0) begin
        fresh[i] = 1'b1;
        s.held[i] = 1'b1;
        ph = 1;
      end else if (l[i] && ph == 1) begin
        ph = -int'(s.lockout);
        s.held[i] = 1'b0;
      end else if (ph < 0) begin
        ph++;
      end
      s.phase[i] = 9'(ph);
    end
    if (s.cool != 0) s.cool--;
    // mode rules
    case (s.mode)
      MODE_IDLE: begin
        if (s.recoil == RCL_AUTO) begin
          if (s.held[TRG_IDX] && s.cool == 0) begin
            s.sol = 1'b1;
            s.pend = 1'b1;
            s.cool = 3'(AUTO_CD);
          end
        end else if (s.recoil == RCL_SELF && fresh[TRG_IDX]) begin
          s.sol = 1'b1;
          s.pend = 1'b1;
        end
        if (fresh[CAL_IDX]) begin
          s.lamp = 1'b1;
          s.mode = MODE_SERVICE;
        end
      end
      MODE_SERVICE: begin
        if (fresh[TRG_IDX]) s.mode = MODE_CAL_TL;
        if (fresh[CAL_IDX]) begin
          s.mode = MODE_IDLE;
          s.lamp = 1'b0;
        end
        if (fresh[BT0_IDX]) begin
          case (s.recoil)
            RCL_SELF: s.recoil = RCL_AUTO;
            RCL_AUTO: s.recoil = RCL_OFF;
            default: begin
              s.recoil = RCL_SELF;
              s.sol = 1'b1;
              s.pend = 1'b1;
            end
          endcase
        end
        if (s.held == COMBO_FULL) begin
          s.mode = MODE_SHUTDOWN;
          r.shut = 1'b1;
        end
      end
      MODE_CAL_TL: begin
        if (fresh[TRG_IDX]) begin
          r.cap_tl = 1'b1;
          s.mode = MODE_CAL_LR;
        end else if (fresh[CAL_IDX]) begin
          s.mode = MODE_IDLE;
          s.lamp = 1'b0;
        end
      end
      MODE_CAL_LR: begin
        if (fresh[TRG_IDX]) begin
          r.cap_lr = 1'b1;
          s.mode = MODE_IDLE;
          s.lamp = 1'b0;
        end else if (fresh[CAL_IDX]) begin
          s.mode = MODE_IDLE;
          s.lamp = 1'b0;
        end
      end
      default: ;
    endcase
    // solenoid pulse lasts one tick
    if (!s.pend) s.sol = 1'b0;
    else s.pend = 1'b0;
    // late shutdown combination
    if (s.held == COMBO_TRG_MAG && s.mode == MODE_SERVICE) begin
      s.mode = MODE_SHUTDOWN;
      r.shut = 1'b1;
    end
    r.pressed = s.held;
    r.fresh = fresh;
    r.fire = s.sol;
    r.mode = s.mode;
    r.recoil = s.recoil;
    r.lamp = s.lamp;
    return r;
  endfunction

  // random request biased toward ready buttons pressing and held ones releasing;
  // anything that would shut the block down early becomes a release of all
  function automatic void pick_request(output logic [NB-1:0] e, output logic [NB-1:0] l);
    logic [NB-1:0] ready_m;
    logic [NB-1:0] held_m;
    ctl_state_t    trial;
    tick_res_t     r;
    for (int i = 0; i < NB; i++) begin
      ready_m[i] = (ctl_state.phase[i] == '0);
      held_m[i] = (ctl_state.phase[i] == 9'd1);
    end
    if ($urandom_range(0, 4) == 0) begin
      e = NB'($urandom);
      l = NB'($urandom);
    end else begin
      e = ready_m & NB'($urandom) & NB'($urandom);
      l = (held_m & NB'($urandom) & NB'($urandom)) | (~held_m & NB'($urandom) & NB'($urandom));
    end
    trial = ctl_state;
    r = run_tick(trial, e, l);
    if (r.shut) begin
      e = '0;
      l = '1;
    end
  endfunction

  // send one request in bursts with random gaps, predict on acceptance
  task automatic send_request(input logic [NB-1:0] e, input logic [NB-1:0] l,
                              input logic typed, input tick_res_t typed_res);
    int        gap;
    tick_res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.edge_flags <= e;
    in_ch.pin_levels <= l;
    do @(posedge clk); while (!in_ch.ready);
    r = run_tick(ctl_state, e, l);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // lockout write once every result is out
  task automatic set_lockout(input logic [LOCK_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    ctl_state.lockout = v;
    burst_left = 0;
  endtask

  task automatic flag_field(input string what, input logic [NB-1:0] want,
                            input logic [NB-1:0] got);
    if (want !== got) begin
      mism_count++;
      if (mism_count <= 10) begin
        $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mism_count++;
        if (mism_count <= 10) $display("result with no request outstanding");
      end else begin
        oldest_res = pending_results.pop_front();
        flag_field("pressed_mask", oldest_res.pressed, out_ch.pressed_mask);
        flag_field("new_press_mask", oldest_res.fresh, out_ch.new_press_mask);
        flag_field("solenoid_fire", NB'(oldest_res.fire), NB'(out_ch.solenoid_fire));
        flag_field("operating_mode", NB'(oldest_res.mode), NB'(out_ch.operating_mode));
        flag_field("recoil_setting", NB'(oldest_res.recoil), NB'(out_ch.recoil_setting));
        flag_field("calibration_led", NB'(oldest_res.lamp), NB'(out_ch.calibration_led));
        flag_field("capture_top_left", NB'(oldest_res.cap_tl),
                   NB'(out_ch.capture_top_left));
        flag_field("capture_low_right", NB'(oldest_res.cap_lr),
                   NB'(out_ch.capture_low_right));
        flag_field("shutdown_request", NB'(oldest_res.shut), NB'(out_ch.shutdown_request));
      end
    end
  end

  // result receiver: free-running, patterned or mostly stalled stretches
  initial begin
    int          stall_style;
    int          stall_left;
    logic [15:0] stall_pat;
    logic [3:0]  stall_pos;
    out_ch.ready = 1'b0;
    stall_style = 0;
    stall_left = 0;
    stall_pat = '1;
    stall_pos = '0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_style = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 80);
        if (stall_style == 2) stall_pat = 16'($urandom & $urandom & $urandom) | 16'h1;
        else stall_pat = 16'($urandom) | 16'h1;
      end
      stall_left--;
      stall_pos++;
      out_ch.ready <= (stall_style == 0) ? 1'b1 : stall_pat[stall_pos];
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [NB-1:0]     e;
    logic [NB-1:0]     l;
    logic [NB-1:0]     combo;
    logic [LOCK_W-1:0] lock_v;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.edge_flags = '0;
    in_ch.pin_levels = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    // reset state: all ready, idle, self recoil, lockout at its reset value
    ctl_state = '0;
    ctl_state.lockout = LOCKOUT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int k = 0; k < N_DIR; k++) begin
      if (DIR_TABLE[k].kind == ROW_LOCK) begin
        set_lockout(DIR_TABLE[k].lock);
      end else begin
        send_request(DIR_TABLE[k].edges, DIR_TABLE[k].levels, DIR_TABLE[k].typed,
                     DIR_TABLE[k].want);
      end
    end

    // random phases over several lockout settings
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: lock_v = 8'd1;
        1: lock_v = 8'd255;
        2: lock_v = 8'd0;
        3: lock_v = 8'($urandom_range(2, 20));
        4: lock_v = LOCKOUT_RESET;
        default: lock_v = 8'($urandom_range(0, 255));
      endcase
      set_lockout(lock_v);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        pick_request(e, l);
        send_request(e, l, 1'b0, NO_RES);
      end
    end

    // release everything and let every button come back to ready
    set_lockout(8'd0);
    while (ctl_state.phase != '0) send_request('0, '1, 1'b0, NO_RES);
    if (ctl_state.mode != MODE_IDLE) begin
      send_request(CAL_M, '0, 1'b0, NO_RES);
      send_request('0, CAL_M, 1'b0, NO_RES);
    end

    // shutdown by one of the two combinations, entered from service
    combo = ($urandom_range(0, 1) == 0) ? COMBO_FULL : COMBO_TRG_MAG;
    send_request(combo, '0, 1'b0, NO_RES);
    send_request(CAL_M, '0, 1'b0, NO_RES);
    send_request('0, CAL_M, 1'b0, NO_RES);

    // qualification keeps running in shutdown
    for (int n = 0; n < 20; n++) begin
      pick_request(e, l);
      send_request(e, l, 1'b0, NO_RES);
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mism_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
